### sv/dtd_pkg.sv
// Shared types, register indexes and the LED code table for the DTMF tone decision block.
package dtd_pkg;

  localparam int ROW_LANES = 4;
  localparam int COL_LANES = 3;
  localparam int LANES     = ROW_LANES + COL_LANES;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_QUARTERS = 2'd1;

  localparam logic [7:0] FRAME_LENGTH_RST   = 8'd32;
  localparam logic [5:0] RATIO_QUARTERS_RST = 6'd10;

  localparam logic [3:0] SYM_NONE = 4'd0;
  localparam logic [3:0] LED_NONE = 4'd15;

  // Per-lane control strobes from the sequencer
  typedef struct packed {
    logic upd;    // item accepted: fold sample into the peak
    logic close;  // this item closes the envelope frame
    logic cmp;    // evaluate the dominance test
  } lane_ctl_t;

  // LED code of a key symbol, first LED as msb
  function automatic logic [3:0] led_code(input logic [3:0] sym);
    logic [3:0] led;
    case (sym)
      4'd1, 4'd2, 4'd3, 4'd4, 4'd5,
      4'd6, 4'd7, 4'd8, 4'd9: led = sym;
      4'd10:   led = 4'd12;
      4'd11:   led = 4'd0;
      4'd12:   led = 4'd13;
      default: led = LED_NONE;
    endcase
    return led;
  endfunction

endpackage

### sv/dtmf_tone_decision_core.sv
// Top level of the DTMF tone decision block: sequencer, seven tone lanes and output register.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item of seven band samples,
//   four row bands and three column bands, signed SAMPLE_WIDTH bits each.
//   Result channel (out_valid/out_ready) returns one item per input item:
//   the key symbol (0 = none), its LED code and a frame-closed flag.
//   Configuration: cfg_we with cfg_index 0 writes frame_length, index 1
//   writes ratio_quarters; other indexes are ignored. Write only when idle.
// Pipeline and flow:
//   The lane peak/envelope update lands at the accepting edge, then the
//   per-lane ratio multiply and compare is registered, then the merge
//   loads the output register. One item is in flight at a time and in_ready
//   returns the cycle after the merge, so a new item is taken only once the
//   last one has left the merge step.
// Reset (rst_n, synchronous, active low) clears peaks, amplitudes, the frame
//   counter and restores frame_length = 32 and ratio_quarters = 10.
// Stall: a result waits in the output register while out_ready is low; the
//   next item may still be taken and worked on, and it holds in the merge
//   step until the register frees up.
module dtmf_tone_decision_core #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_row_tone_0,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_row_tone_1,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_row_tone_2,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_row_tone_3,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_col_tone_0,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_col_tone_1,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_col_tone_2,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [3:0]                           out_symbol,
  output logic [3:0]                           out_led_pattern,
  output logic                                 out_frame_closed,
  input  logic                                 cfg_we,
  input  logic [dtd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dtd_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import dtd_pkg::*;

  localparam int W = SAMPLE_WIDTH;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_MRG  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [7:0] frame_length_r, frame_length_nxt;
  logic [5:0] ratio_r, ratio_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [8:0] cnt_inc;
  logic       close;
  logic       closed_r, closed_nxt;
  logic       in_fire, out_load;
  logic       out_valid_r, out_valid_nxt;
  logic [3:0] out_symbol_r, out_symbol_nxt;
  logic [3:0] out_led_r, out_led_nxt;
  logic       out_closed_r, out_closed_nxt;

  logic signed [W-1:0] samp [LANES];
  logic [W-1:0]        amp [LANES];
  logic [W+1:0]        others [LANES];
  logic [W+1:0]        row_sum, col_sum;
  logic [LANES-1:0]    dom;
  lane_ctl_t           ctl;
  logic [3:0]          mrg_symbol, mrg_led;

  assign samp[0] = in_row_tone_0;
  assign samp[1] = in_row_tone_1;
  assign samp[2] = in_row_tone_2;
  assign samp[3] = in_row_tone_3;
  assign samp[4] = in_col_tone_0;
  assign samp[5] = in_col_tone_1;
  assign samp[6] = in_col_tone_2;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state_r == S_MRG) && (!out_valid_r || out_ready);

  // Configuration registers
  always_comb begin
    frame_length_nxt = frame_length_r;
    ratio_nxt        = ratio_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_LENGTH:   frame_length_nxt = cfg_wdata;
        CFG_RATIO_QUARTERS: ratio_nxt        = cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // Frame counter; a 9-bit increment lets a frame run 256 samples
  assign cnt_inc = {1'b0, cnt_r} + 9'd1;
  assign close   = cnt_inc > {1'b0, frame_length_r};

  always_comb begin
    cnt_nxt    = cnt_r;
    closed_nxt = closed_r;
    if (in_fire) begin
      cnt_nxt    = close ? 8'd0 : cnt_inc[7:0];
      closed_nxt = close;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_MRG;
      S_MRG:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign ctl.upd   = in_fire;
  assign ctl.close = close;
  assign ctl.cmp   = (state_r == S_CMP);

  // Group sums for the "others" term of each lane
  assign row_sum = (W+2)'(amp[0]) + (W+2)'(amp[1]) + (W+2)'(amp[2]) + (W+2)'(amp[3]);
  assign col_sum = (W+2)'(amp[4]) + (W+2)'(amp[5]) + (W+2)'(amp[6]);

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    if (g < ROW_LANES) begin : g_row
      assign others[g] = row_sum - (W+2)'(amp[g]);
    end else begin : g_col
      assign others[g] = col_sum - (W+2)'(amp[g]);
    end

    dtd_lane #(.W(W)) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .sample (samp[g]),
      .ratio  (ratio_r),
      .others (others[g]),
      .amp    (amp[g]),
      .dom    (dom[g])
    );
  end

  dtd_merge u_merge (
    .dom_row (dom[ROW_LANES-1:0]),
    .dom_col (dom[LANES-1:ROW_LANES]),
    .symbol  (mrg_symbol),
    .led     (mrg_led)
  );

  // Output register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_symbol_nxt = out_symbol_r;
    out_led_nxt    = out_led_r;
    out_closed_nxt = out_closed_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_symbol_nxt = mrg_symbol;
      out_led_nxt    = mrg_led;
      out_closed_nxt = closed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      frame_length_r <= FRAME_LENGTH_RST;
      ratio_r        <= RATIO_QUARTERS_RST;
      cnt_r          <= 8'd0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      frame_length_r <= frame_length_nxt;
      ratio_r        <= ratio_nxt;
      cnt_r          <= cnt_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    closed_r     <= closed_nxt;
    out_symbol_r <= out_symbol_nxt;
    out_led_r    <= out_led_nxt;
    out_closed_r <= out_closed_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_symbol       = out_symbol_r;
  assign out_led_pattern  = out_led_r;
  assign out_frame_closed = out_closed_r;

`ifndef SYNTH
  // An accepted item always moves on to the compare step
  a_fire_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_CMP)
    else $error("accepted item did not enter compare step");

  // A closing item restarts the frame counter
  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && close) |=> cnt_r == 8'd0)
    else $error("frame counter not cleared on frame close");

  // A new result appears only out of the merge step
  a_out_from_merge: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_MRG)
    else $error("result raised outside merge step");

  // Symbol and LED code agree
  a_led_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_led_r == led_code(out_symbol_r)) && (out_symbol_r <= 4'd12))
    else $error("LED code does not match symbol");
`endif

endmodule

### sv/dtd_lane.sv
// One tone lane: peak tracker, envelope amplitude and dominance compare.
module dtd_lane #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dtd_pkg::lane_ctl_t  ctl,
  input  logic signed [W-1:0] sample,
  input  logic [5:0]          ratio,
  input  logic [W+1:0]        others,
  output logic [W-1:0]        amp,
  output logic                dom
);
  import dtd_pkg::*;

  logic [W-1:0] mag;
  logic [W-1:0] peak_max;
  logic [W:0]   amp_sum;
  logic [W-1:0] peak_r, peak_nxt;
  logic [W-1:0] amp_r, amp_nxt;
  logic [W+7:0] lhs, rhs;
  logic         dom_r, dom_nxt;

  // Magnitude; the most negative code maps to 2^(W-1), which fits unsigned
  assign mag      = sample[W-1] ? (~sample + 1'b1) : sample;
  assign peak_max = (mag > peak_r) ? mag : peak_r;
  assign amp_sum  = {1'b0, peak_max} + {1'b0, amp_r};

  // Peak and envelope update
  always_comb begin
    peak_nxt = peak_r;
    amp_nxt  = amp_r;
    if (ctl.upd) begin
      if (ctl.close) begin
        amp_nxt  = amp_sum[W:1];
        peak_nxt = '0;
      end else begin
        peak_nxt = peak_max;
      end
    end
  end

  // Dominance: 4*A > ratio * (sum of the other lanes of the group)
  assign lhs     = {6'd0, amp_r, 2'b00};
  assign rhs     = (W+8)'(ratio) * (W+8)'(others);
  assign dom_nxt = ctl.cmp ? (lhs > rhs) : dom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
      amp_r  <= '0;
      dom_r  <= 1'b0;
    end else begin
      peak_r <= peak_nxt;
      amp_r  <= amp_nxt;
      dom_r  <= dom_nxt;
    end
  end

  assign amp = amp_r;
  assign dom = dom_r;

endmodule

### sv/dtd_merge.sv
// Merging stage: picks the first dominant row and column and forms the key and LED code.
module dtd_merge (
  input  logic [dtd_pkg::ROW_LANES-1:0] dom_row,
  input  logic [dtd_pkg::COL_LANES-1:0] dom_col,
  output logic [3:0]                    symbol,
  output logic [3:0]                    led
);
  import dtd_pkg::*;

  logic [2:0] row;
  logic [1:0] col;
  logic [3:0] base;

  // Priority pick: lowest-numbered dominant band wins
  always_comb begin
    row = 3'd0;
    for (int i = ROW_LANES - 1; i >= 0; i--) begin
      if (dom_row[i]) row = 3'(i + 1);
    end
    col = 2'd0;
    for (int j = COL_LANES - 1; j >= 0; j--) begin
      if (dom_col[j]) col = 2'(j + 1);
    end
  end

  // Key number col + 3*(row-1)
  always_comb begin
    case (row)
      3'd1:    base = 4'd0;
      3'd2:    base = 4'd3;
      3'd3:    base = 4'd6;
      3'd4:    base = 4'd9;
      default: base = 4'd0;
    endcase
    if (row != 3'd0 && col != 2'd0) begin
      symbol = base + {2'b00, col};
    end else begin
      symbol = SYM_NONE;
    end
  end

  assign led = led_code(symbol);

endmodule
